/* rtl/csv_stream_tokenizer_defines.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef CSV_STREAM_TOKENIZER_DEFINES_SVH
`define CSV_STREAM_TOKENIZER_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define CST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define CST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/cst_pkg.sv */
// Types and constants shared by the CSV stream tokenizer modules.
package cst_pkg;

  // One input request: a text byte or the end-of-input marker.
  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic       row_end;
    logic       last;
  } out_item_t;

  // Input kind codes.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOI  = 1'b1;

  // Result kind codes.
  localparam logic [1:0] RK_BYTE        = 2'd0;
  localparam logic [1:0] RK_FIELD_END   = 2'd1;
  localparam logic [1:0] RK_ABANDONED   = 2'd2;
  localparam logic [1:0] RK_WS_OVERFLOW = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic       CFG_SEP       = 1'b0;
  localparam logic       CFG_QUOTE     = 1'b1;
  localparam logic [7:0] SEP_RESET     = 8'd44;
  localparam logic [7:0] QUOTE_RESET   = 8'd34;

  // Characters with a fixed meaning.
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_HASH  = 8'd35;

  // Class the front end gives each input request.
  typedef enum logic [1:0] {
    CMD_TEXT,
    CMD_WS,
    CMD_NL,
    CMD_EOI
  } cmd_class_e;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    cmd_class_e cls;
    logic       is_hash;
    logic [7:0] data;
  } cmd_t;

  // Position within the current raw line; the spare code acts as a comment line.
  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_LINE    = 2'd1,
    PH_COMMENT = 2'd2
  } line_phase_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_REPLAY,
    BK_FINAL,
    BK_LF,
    BK_ABANDON
  } bk_state_e;

endpackage

/* rtl/cst_front.sv */
// Front end: classifies input requests and queues them for the back end.
module cst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  cst_pkg::in_item_t item_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cst_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] CmdDepth = 2'd2;

  cst_pkg::cmd_t cmd_in;
  cst_pkg::cmd_t queue_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  // Sort each request into end of input, line end, whitespace or other text.
  always_comb begin
    cmd_in.cls     = cst_pkg::CMD_TEXT;
    cmd_in.is_hash = (item_i.byte_value == cst_pkg::CHAR_HASH);
    cmd_in.data    = item_i.byte_value;
    if (item_i.kind == cst_pkg::KIND_EOI) begin
      cmd_in.cls = cst_pkg::CMD_EOI;
    end else if (item_i.byte_value == cst_pkg::CHAR_LF) begin
      cmd_in.cls = cst_pkg::CMD_NL;
    end else if (item_i.byte_value == cst_pkg::CHAR_SPACE ||
                 item_i.byte_value == cst_pkg::CHAR_TAB ||
                 item_i.byte_value == cst_pkg::CHAR_CR) begin
      cmd_in.cls = cst_pkg::CMD_WS;
    end
  end

  // Two-entry command queue.
  assign full        = (cnt_q == CmdDepth);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* rtl/cst_back.sv */
// Back end: runs the line trimming and CSV parse, one result per cycle at most.
module cst_back #(
  parameter int unsigned WS_HOLD_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         sep_i,
  input  logic [7:0]         quote_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cst_pkg::cmd_t      cmd_i,
  output logic               res_push_o,
  output cst_pkg::out_item_t res_o,
  input  logic               res_full_i
);

  localparam int unsigned IdxW = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WS_HOLD_DEPTH + 1);
  localparam logic [CntW-1:0] HoldMax = CntW'(WS_HOLD_DEPTH);

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic emit;
    logic field_end;
  } parse_t;

  // Parse one byte of the trimmed line against the current quote state.
  function automatic parse_t parse_byte(input logic [7:0] c, input logic iq,
                                        input logic qp, input logic [7:0] sep,
                                        input logic [7:0] quo);
    parse_t p;
    logic   done;
    p           = '0;
    p.in_quotes = iq;
    done        = 1'b0;
    if (qp) begin
      if (c == quo) begin
        p.emit = 1'b1;
        done   = 1'b1;
      end else begin
        p.in_quotes = 1'b0;
      end
    end
    if (!done) begin
      if (p.in_quotes) begin
        if (c == quo) begin
          p.quote_pending = 1'b1;
        end else begin
          p.emit = 1'b1;
        end
      end else if (c == sep) begin
        p.emit      = 1'b1;
        p.field_end = 1'b1;
      end else if (c == quo) begin
        p.in_quotes = 1'b1;
      end else begin
        p.emit = 1'b1;
      end
    end
    return p;
  endfunction

  cst_pkg::bk_state_e   state_q, state_d;
  cst_pkg::line_phase_e phase_q, phase_d;
  logic                 iq_q, iq_d, qp_q, qp_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      idx_nxt;
  cst_pkg::cmd_t        cur_q, cur_d;
  logic [7:0]           hold_mem [WS_HOLD_DEPTH];
  logic [7:0]           rdata_q;
  cst_pkg::out_item_t   pend_q, res;
  logic                 pend_valid_q, pend_closed_q;
  logic                 take, res_valid, step_end, apply_parse;
  logic                 wr_en, rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [7:0]           parse_c;
  parse_t               parsed;
  logic                 push_needed, adv;
  logic                 cr_case;

  assign idx_nxt = CntW'(idx_q) + 1'b1;

  // A line end inside open quotes turns into CR and LF field bytes.
  assign cr_case = (phase_q == cst_pkg::PH_LINE) && iq_q && !qp_q;

  // The byte to parse comes from the new command, the hold memory or the saved command.
  always_comb begin
    case (state_q)
      cst_pkg::BK_IDLE:   parse_c = cmd_i.data;
      cst_pkg::BK_REPLAY: parse_c = rdata_q;
      default:            parse_c = cur_q.data;
    endcase
  end

  assign parsed = parse_byte(parse_c, iq_q, qp_q, sep_i, quote_i);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cst_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.cls == cst_pkg::CMD_TEXT &&
            phase_q == cst_pkg::PH_LINE && count_q != '0) begin
          state_d = cst_pkg::BK_REPLAY;
        end else if (cmd_valid_i && cr_case &&
                     (cmd_i.cls == cst_pkg::CMD_NL || cmd_i.cls == cst_pkg::CMD_EOI)) begin
          state_d = cst_pkg::BK_LF;
        end
      end
      cst_pkg::BK_REPLAY: begin
        if (idx_nxt == count_q) begin
          state_d = cst_pkg::BK_FINAL;
        end
      end
      cst_pkg::BK_FINAL:   state_d = cst_pkg::BK_IDLE;
      cst_pkg::BK_LF: begin
        state_d = (cur_q.cls == cst_pkg::CMD_EOI) ? cst_pkg::BK_ABANDON : cst_pkg::BK_IDLE;
      end
      cst_pkg::BK_ABANDON: state_d = cst_pkg::BK_IDLE;
      default:             state_d = cst_pkg::BK_IDLE;
    endcase
  end

  // Per-state work: result, parse state update and hold memory access.
  always_comb begin
    take        = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    step_end    = 1'b0;
    apply_parse = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    iq_d        = iq_q;
    qp_d        = qp_q;
    phase_d     = phase_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    unique case (state_q)
      cst_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          take  = 1'b1;
          cur_d = cmd_i;
          unique case (cmd_i.cls) inside
            cst_pkg::CMD_WS: begin
              step_end = 1'b1;
              if (phase_q == cst_pkg::PH_LINE) begin
                if (count_q < HoldMax) begin
                  wr_en   = 1'b1;
                  count_d = count_q + 1'b1;
                end else begin
                  res_valid       = 1'b1;
                  res.result_kind = cst_pkg::RK_WS_OVERFLOW;
                end
              end
            end
            cst_pkg::CMD_NL, cst_pkg::CMD_EOI: begin
              if (cr_case) begin
                res_valid       = 1'b1;
                res.result_kind = cst_pkg::RK_BYTE;
                res.data_byte   = cst_pkg::CHAR_CR;
              end else begin
                if (phase_q == cst_pkg::PH_LINE) begin
                  // A pending quote is closed by the line end.
                  iq_d            = 1'b0;
                  qp_d            = 1'b0;
                  res_valid       = 1'b1;
                  res.result_kind = cst_pkg::RK_FIELD_END;
                  res.row_end     = 1'b1;
                end else if (cmd_i.cls == cst_pkg::CMD_EOI && iq_q) begin
                  res_valid       = 1'b1;
                  res.result_kind = cst_pkg::RK_ABANDONED;
                end
                step_end = 1'b1;
                count_d  = '0;
                phase_d  = cst_pkg::PH_START;
                if (cmd_i.cls == cst_pkg::CMD_EOI) begin
                  iq_d = 1'b0;
                  qp_d = 1'b0;
                end
              end
            end
            default: begin
              unique case (phase_q)
                cst_pkg::PH_START: begin
                  step_end = 1'b1;
                  if (!iq_q && cmd_i.is_hash) begin
                    phase_d = cst_pkg::PH_COMMENT;
                  end else begin
                    phase_d     = cst_pkg::PH_LINE;
                    apply_parse = 1'b1;
                  end
                end
                cst_pkg::PH_LINE: begin
                  if (count_q == '0) begin
                    step_end    = 1'b1;
                    apply_parse = 1'b1;
                  end else begin
                    // Fetch the first held whitespace byte.
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    idx_d   = '0;
                  end
                end
                default: step_end = 1'b1;
              endcase
            end
          endcase
        end
      end
      cst_pkg::BK_REPLAY: begin
        apply_parse = 1'b1;
        idx_d       = idx_nxt[IdxW-1:0];
        if (idx_nxt != count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_nxt[IdxW-1:0];
        end
      end
      cst_pkg::BK_FINAL: begin
        apply_parse = 1'b1;
        count_d     = '0;
        step_end    = 1'b1;
      end
      cst_pkg::BK_LF: begin
        res_valid       = 1'b1;
        res.result_kind = cst_pkg::RK_BYTE;
        res.data_byte   = cst_pkg::CHAR_LF;
        if (cur_q.cls != cst_pkg::CMD_EOI) begin
          step_end = 1'b1;
          count_d  = '0;
          phase_d  = cst_pkg::PH_START;
        end
      end
      cst_pkg::BK_ABANDON: begin
        res_valid       = 1'b1;
        res.result_kind = cst_pkg::RK_ABANDONED;
        step_end        = 1'b1;
        iq_d            = 1'b0;
        qp_d            = 1'b0;
        phase_d         = cst_pkg::PH_START;
        count_d         = '0;
      end
      default: ;
    endcase
    if (apply_parse) begin
      iq_d = parsed.in_quotes;
      qp_d = parsed.quote_pending;
      if (parsed.emit) begin
        res_valid       = 1'b1;
        res.result_kind = parsed.field_end ? cst_pkg::RK_FIELD_END : cst_pkg::RK_BYTE;
        res.data_byte   = parsed.field_end ? 8'd0 : parse_c;
      end
    end
  end

  // The newest result is held until the next result or step end fixes its last flag.
  assign push_needed = pend_valid_q && (res_valid || pend_closed_q || step_end);
  assign adv         = !(push_needed && res_full_i);
  assign res_push_o  = push_needed && adv;
  assign cmd_ready_o = take && adv;

  always_comb begin
    res_o      = pend_q;
    res_o.last = pend_closed_q || (step_end && !res_valid);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= cst_pkg::BK_IDLE;
      phase_q       <= cst_pkg::PH_START;
      iq_q          <= 1'b0;
      qp_q          <= 1'b0;
      count_q       <= '0;
      idx_q         <= '0;
      pend_valid_q  <= 1'b0;
      pend_closed_q <= 1'b0;
    end else if (adv) begin
      state_q <= state_d;
      phase_q <= phase_d;
      iq_q    <= iq_d;
      qp_q    <= qp_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (res_valid) begin
        pend_valid_q  <= 1'b1;
        pend_closed_q <= step_end;
      end else if (push_needed) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cur_q <= cur_d;
      if (res_valid) begin
        pend_q <= res;
      end
    end
  end

  // Hold memory for interior whitespace, one write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en && adv) begin
      hold_mem[count_q[IdxW-1:0]] <= cmd_i.data;
    end
    if (rd_en && adv) begin
      rdata_q <= hold_mem[rd_addr];
    end
  end

endmodule

/* rtl/cst_res_fifo.sv */
// Two-entry result queue that drives the result ports.
module cst_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cst_pkg::out_item_t data_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output cst_pkg::out_item_t data_o
);

  localparam logic [1:0] ResDepth = 2'd2;

  cst_pkg::out_item_t queue_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == ResDepth);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = queue_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/csv_stream_tokenizer.sv */
// Top level of the CSV stream tokenizer: config registers, front end, back end, result queue.
//
//   channel   direction  handshake               payload
//   input     in         push / full             item_i (kind, byte_value)
//   result    out        empty / pop             result_o (result_kind, data_byte, row_end, last)
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Whitespace, line ends that do not sit inside open quotes, comment bytes and bytes with no
// held whitespace are handled in the idle state alone; a byte after held whitespace first
// reads the hold memory through its single read port, then replays each held byte and is
// parsed last. A line end inside open quotes on a started line gives CR and then LF, and
// end of input there adds an abandon result. Reset is asynchronous, with no clearing pass.
// The back end stalls only while a result waits on a full result queue. The input queue holds two requests.
`include "csv_stream_tokenizer_defines.svh"

module csv_stream_tokenizer #(
  parameter int unsigned WS_HOLD_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  cst_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output cst_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic [7:0]         sep_q, quote_q;
  logic               cmd_valid, cmd_ready;
  cst_pkg::cmd_t      cmd;
  logic               res_push, res_full;
  cst_pkg::out_item_t res;

  // Configuration registers are always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= cst_pkg::SEP_RESET;
      quote_q <= cst_pkg::QUOTE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cst_pkg::CFG_SEP:   sep_q   <= cfg_data_i;
        cst_pkg::CFG_QUOTE: quote_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  cst_back #(
    .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sep_i       (sep_q),
    .quote_i     (quote_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  cst_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (result_o)
  );

  // Consistency checks across the front end, back end and result queue.
  `CST_ASSERT_ALWAYS(a_no_full_in_reset, !rst_ni |=> !full, "input queue full during reset")
  `CST_ASSERT(a_push_has_room, res_push |-> !res_full, "result pushed into a full queue")
  `CST_ASSERT(a_take_has_cmd, cmd_ready |-> cmd_valid, "back end took a missing command")
  `CST_ASSERT(a_empty_holds, (empty && !res_push) |=> empty, "result appeared without a push")

endmodule

/* tb/csv_stream_tokenizer_tb.sv */
// Self-checking testbench for the CSV stream tokenizer, with a built-in parsing predictor.
module csv_stream_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int unsigned WS_DEPTH      = 16;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RESULT_HOLD   = 300;

  // Clock, reset and block ports.
  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic       full;
  in_item_t   in_item   = '0;
  logic       empty;
  logic       pop       = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_SEP;
  logic [7:0] cfg_data  = '0;

  // Shadow copy of the tokenizer state used for prediction.
  logic [7:0]  sep_reg;
  logic [7:0]  quote_reg;
  bit          quoted;
  bit          quote_wait;
  line_phase_e phase;
  logic [7:0]  held_ws [WS_DEPTH];
  int unsigned hold_count;

  // Tokens produced by the item being predicted, and all tokens still owed by the block.
  out_item_t step_tokens[$];
  out_item_t pending_tokens[$];

  // Run bookkeeping.
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned rows_sent;
  int unsigned tokens_checked;
  int unsigned cfg_writes;
  int unsigned idle_cycles;
  bit          burst_mode;
  int unsigned pop_hold_req;
  bit          hold_active;
  out_item_t   want_tok;

  csv_stream_tokenizer #(
    .WS_HOLD_DEPTH(WS_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (in_item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Tokenizer predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR;
  endfunction

  function void emit_token(logic [1:0] kind, logic [7:0] data, logic row_end);
    out_item_t tok;
    tok.result_kind = kind;
    tok.data_byte   = (kind == RK_BYTE) ? data : 8'd0;
    tok.row_end     = row_end;
    tok.last        = 1'b0;
    step_tokens     = {step_tokens, tok};
  endfunction

  // One byte of the trimmed line through the quote and separator rules.
  function void parse_char(logic [7:0] c);
    if (quote_wait) begin
      quote_wait = 1'b0;
      if (c == quote_reg) begin
        emit_token(RK_BYTE, c, 1'b0);
        return;
      end
      quoted = 1'b0;
    end
    if (quoted) begin
      if (c == quote_reg) quote_wait = 1'b1;
      else emit_token(RK_BYTE, c, 1'b0);
      return;
    end
    if (c == sep_reg) emit_token(RK_FIELD_END, 8'd0, 1'b0);
    else if (c == quote_reg) quoted = 1'b1;
    else emit_token(RK_BYTE, c, 1'b0);
  endfunction

  // A raw line ends: held whitespace is trailing and is dropped.
  function void close_line();
    hold_count = 0;
    if (phase == PH_LINE) begin
      if (quote_wait) begin
        quote_wait = 1'b0;
        quoted     = 1'b0;
      end
      if (quoted) begin
        emit_token(RK_BYTE, CHAR_CR, 1'b0);
        emit_token(RK_BYTE, CHAR_LF, 1'b0);
      end else begin
        emit_token(RK_FIELD_END, 8'd0, 1'b1);
      end
    end
    phase = PH_START;
  endfunction

  function void clear_parse_state();
    quoted     = 1'b0;
    quote_wait = 1'b0;
    phase      = PH_START;
    hold_count = 0;
  endfunction

  // Works out the tokens of one accepted request and queues them.
  function void predict_item(in_item_t it);
    logic [7:0] c;
    c = it.byte_value;
    step_tokens.delete();
    if (it.kind == KIND_EOI) begin
      close_line();
      if (quoted) emit_token(RK_ABANDONED, 8'd0, 1'b0);
      clear_parse_state();
    end else if (c == CHAR_LF) begin
      close_line();
    end else if (is_blank(c)) begin
      if (phase == PH_LINE) begin
        if (hold_count < WS_DEPTH) begin
          held_ws[hold_count] = c;
          hold_count++;
        end else begin
          emit_token(RK_WS_OVERFLOW, 8'd0, 1'b0);
        end
      end
    end else if (phase == PH_START) begin
      if (!quoted && c == CHAR_HASH) begin
        phase = PH_COMMENT;
      end else begin
        phase = PH_LINE;
        parse_char(c);
      end
    end else if (phase == PH_LINE) begin
      // A later non-blank byte proves the held whitespace was interior.
      for (int i = 0; i < hold_count; i++) parse_char(held_ws[i]);
      hold_count = 0;
      parse_char(c);
    end
    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
    pending_tokens = {pending_tokens, step_tokens};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one request and returns at the edge that accepts it. The caller either
  // sends the next request in the same step or lowers push through wait_idle.
  task automatic send_item(logic kind, logic [7:0] value);
    int unsigned gap;
    in_item_t    it;
    gap           = burst_mode ? 0 : draw_gap();
    it.kind       = kind;
    it.byte_value = value;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    predict_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_TEXT, s[i]);
  endtask

  // Stops offering input and waits until every owed token has come and the block is quiet.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SEP) sep_reg = value;
    else quote_reg = value;
    cfg_writes++;
  endtask

  // Result side: random pops, bursts of steady pops, and an occasional long hold.
  initial begin
    int unsigned gap;
    int unsigned hold_len;
    bit          steady;
    steady = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (pop_hold_req > 0) begin
        hold_len    = pop_hold_req;
        pop        <= 1'b0;
        hold_active = 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_active  = 1'b0;
        pop_hold_req = 0;
      end else begin
        if ($urandom_range(0, 31) == 0) steady = 1'($urandom_range(0, 1));
        gap = steady ? 0 : draw_gap();
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Each popped token against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      tokens_checked++;
      if (pending_tokens.size() == 0) begin
        $error("token popped with none owed: kind %0d data %0h", out_item.result_kind,
               out_item.data_byte);
        fail_count++;
      end else begin
        want_tok = pending_tokens.pop_front();
        if (out_item.result_kind !== want_tok.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want_tok.result_kind,
                 out_item.result_kind);
          fail_count++;
        end
        if (out_item.data_byte !== want_tok.data_byte) begin
          $error("data_byte: expected %0h, actual %0h", want_tok.data_byte, out_item.data_byte);
          fail_count++;
        end
        if (out_item.row_end !== want_tok.row_end) begin
          $error("row_end: expected %0b, actual %0b", want_tok.row_end, out_item.row_end);
          fail_count++;
        end
        if (out_item.last !== want_tok.last) begin
          $error("last: expected %0b, actual %0b", want_tok.last, out_item.last);
          fail_count++;
        end
      end
    end
  end

  // Ends a run that stops moving.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request moved for %0d cycles, %0d tokens still owed.",
                 idle_cycles, pending_tokens.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random row generation
  // ---------------------------------------------------------------------------

  // Mostly letters, sometimes any byte at all.
  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      default: return CHAR_CR;
    endcase
  endfunction

  // Usually no whitespace, often a little, now and then a run near or beyond the hold buffer depth.
  task automatic send_ws_run();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 19);
    if (r < 12) n = 0;
    else if (r < 19) n = $urandom_range(1, 3);
    else n = $urandom_range(15, 19);
    repeat (n) send_item(KIND_TEXT, pick_blank());
  endtask

  task automatic send_random_row();
    int unsigned r;
    int unsigned nf;
    int unsigned n;
    int unsigned k;
    r = $urandom_range(0, 99);
    rows_sent++;
    if (r < 6) begin
      // Comment line.
      send_ws_run();
      send_item(KIND_TEXT, CHAR_HASH);
      n = $urandom_range(0, 5);
      repeat (n) send_item(KIND_TEXT, pick_text_byte());
      send_item(KIND_TEXT, CHAR_LF);
    end else if (r < 10) begin
      // Blank line.
      send_ws_run();
      send_item(KIND_TEXT, CHAR_LF);
    end else if (r < 14) begin
      // Noise: arbitrary bytes with no structure.
      n = $urandom_range(1, 6);
      repeat (n) send_item(KIND_TEXT, 8'($urandom_range(0, 255)));
    end else begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        send_ws_run();
        n = $urandom_range(0, 5);
        if ($urandom_range(0, 2) == 0) begin
          // Quoted field with doubled quotes, separators and line breaks inside.
          send_item(KIND_TEXT, quote_reg);
          repeat (n) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
              send_item(KIND_TEXT, quote_reg);
              send_item(KIND_TEXT, quote_reg);
            end else if (k == 1) begin
              send_item(KIND_TEXT, sep_reg);
            end else if (k == 2) begin
              send_item(KIND_TEXT, CHAR_LF);
            end else begin
              send_item(KIND_TEXT, pick_text_byte());
            end
          end
          if ($urandom_range(0, 19) != 0) send_item(KIND_TEXT, quote_reg);
        end else begin
          repeat (n) send_item(KIND_TEXT, pick_text_byte());
        end
        send_ws_run();
        if (f + 1 < nf) send_item(KIND_TEXT, sep_reg);
      end
      if ($urandom_range(0, 19) == 0) send_item(KIND_EOI, 8'($urandom_range(0, 255)));
      else send_item(KIND_TEXT, CHAR_LF);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain fields, extreme byte values and end of input closing an open row.
  task automatic test_plain_fields();
    send_text("a,b\n");
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_TEXT, CHAR_LF);
    send_item(KIND_TEXT, 8'h63);
    send_item(KIND_EOI, 8'hFF);
    wait_idle();
  endtask

  // Doubled quotes, a quoted field across lines, and end of input inside quotes.
  task automatic test_quoting();
    send_text("\"x\"\"y\"\n");
    send_text("\"p\nq\"\n");
    send_text("\"z");
    send_item(KIND_EOI, 8'h00);
    wait_idle();
  endtask

  // Comment line after leading whitespace, and a line of whitespace only.
  task automatic test_skipped_lines();
    send_text(" #c\n");
    send_text(" \t\r\n");
    wait_idle();
  endtask

  // More interior whitespace than the hold buffer keeps, then replay of what was kept.
  task automatic test_hold_overflow();
    send_item(KIND_TEXT, 8'h61);
    repeat (WS_DEPTH + 2) send_item(KIND_TEXT, CHAR_SPACE);
    send_text("b \n");
    wait_idle();
  endtask

  // The result side stops for a long time while input keeps coming, so both queues fill.
  task automatic test_result_backpressure();
    wait_idle();
    pop_hold_req = RESULT_HOLD;
    while (!hold_active) @(posedge clk_i);
    burst_mode = 1'b1;
    repeat (10) send_text("abc,de\n");
    burst_mode = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_rows(logic [7:0] sep, logic [7:0] quote, int unsigned n_items);
    int unsigned target;
    cfg_write(CFG_SEP, sep);
    cfg_write(CFG_QUOTE, quote);
    target = items_sent + n_items;
    while (items_sent < target) send_random_row();
    wait_idle();
  endtask

  initial begin
    sep_reg   = SEP_RESET;
    quote_reg = QUOTE_RESET;
    clear_parse_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_plain_fields();
    test_quoting();
    test_skipped_lines();
    test_hold_overflow();
    test_result_backpressure();
    // Defaults, both extremes, whitespace registers, equal registers, then another pair.
    test_random_rows(SEP_RESET, QUOTE_RESET, 40);
    test_random_rows(8'h00, 8'hFF, 35);
    test_random_rows(8'hFF, 8'h00, 35);
    test_random_rows(CHAR_TAB, CHAR_SPACE, 35);
    test_random_rows(8'h7C, 8'h7C, 30);   // both '|'
    test_random_rows(8'h3B, 8'h27, 30);   // ';' and single quote

    wait_idle();
    $display("Sent %0d requests, %0d random rows, %0d register writes; checked %0d tokens.",
             items_sent, rows_sent, cfg_writes, tokens_checked);
    $display("Covered comments, blank lines, multiline quotes, hold overflow, %0d-cycle stall.",
             RESULT_HOLD);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
